// File: hw/rtl/tst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and codes for the task slot table: request modes, result
// status codes and the free stack request bundle.
// ----------------------------------------------------------------------------
package tst_pkg;

	// request modes
	localparam logic [1:0] MODE_CREATE = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ZERO    = 3'd1,
		ST_EXISTS  = 3'd2,
		ST_FULL    = 3'd3,
		ST_MISSING = 3'd4
	} tst_status_t;

	// requests from the sequencer to the free stack
	typedef struct packed {
		logic push;
		logic pop;
	} tst_stk_req_t;

endpackage

// File: hw/rtl/tst_free_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_free_stack
// LIFO of free slot numbers held in a synchronous memory. Positions never
// written since reset read as their reset content (slot MAX_TASKS-1-pos), so
// slot 0 starts on top. A pop delivers its slot in the cycle after the request.
// ----------------------------------------------------------------------------
module tst_free_stack #(
	parameter int MAX_TASKS = 16,
	localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
	localparam int CW = $clog2(MAX_TASKS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tst_pkg::tst_stk_req_t req,
	input  logic [SW-1:0]        push_slot,
	output logic [SW-1:0]        pop_slot,
	output logic [CW-1:0]        free_cnt
);
	import tst_pkg::*;

	logic [SW-1:0]        mem [MAX_TASKS];
	logic [MAX_TASKS-1:0] written_q;
	logic [CW-1:0]        cnt_q;
	logic [SW-1:0]        top_pos;
	logic [SW-1:0]        push_pos;
	logic                 can_push;
	logic [SW-1:0]        rd_data_s1;
	logic [SW-1:0]        rd_pos_s1;
	logic                 rd_written_s1;

	// stack positions
	assign top_pos  = SW'(cnt_q - 1'b1);
	assign push_pos = cnt_q[SW-1:0];
	assign can_push = cnt_q < CW'(MAX_TASKS);

	// memory write and registered read of the top entry
	always_ff @(posedge clk) begin
		if (req.push && can_push) begin
			mem[push_pos] <= push_slot;
		end
		if (req.pop) begin
			rd_data_s1 <= mem[top_pos];
			rd_pos_s1  <= top_pos;
		end
	end

	// fill count and written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= CW'(MAX_TASKS);
			written_q     <= '0;
			rd_written_s1 <= 1'b0;
		end else begin
			if (req.push && can_push) begin
				written_q[push_pos] <= 1'b1;
				cnt_q               <= cnt_q + 1'b1;
			end else if (req.pop) begin
				rd_written_s1 <= written_q[top_pos];
				cnt_q         <= cnt_q - 1'b1;
			end
		end
	end

	// unwritten positions hold their reset slot
	assign pop_slot = rd_written_s1 ? rd_data_s1 : (SW'(MAX_TASKS - 1) - rd_pos_s1);
	assign free_cnt = cnt_q;

endmodule

// File: hw/rtl/task_slot_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_slot_table_core
// Fixed pool of task slots with create, lookup and remove by task id.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result shows
// on status, slot_index and slot_valid for a single cycle with done high, and
// must be captured then. Create and remove with task id zero, and the unused
// mode, answer in the cycle after the request. All other requests scan the id
// memory one slot per cycle through its single read port, stopping at the
// matching slot or after the last slot; a create that takes a slot from the
// free stack then passes through S_POP. A new request may be given in the
// cycle that done is shown.
// ----------------------------------------------------------------------------
module task_slot_table_core #(
	parameter int MAX_TASKS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] task_id,
	output logic        done,
	output logic [2:0]  status,
	output logic [3:0]  slot_index,
	output logic        slot_valid
);
	import tst_pkg::*;

	localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_POP
	} state_t;

	state_t               state_q;
	logic [1:0]           mode_q;
	logic [31:0]          id_q;
	logic [CW-1:0]        scan_addr_q;
	logic [31:0]          id_mem [MAX_TASKS];
	logic [MAX_TASKS-1:0] active_q;
	logic [31:0]          rd_data_s1;
	logic [SW-1:0]        idx_s1;
	logic                 vld_s1;
	logic                 done_q;
	tst_status_t          status_q;
	logic [3:0]           slot_q;
	logic                 slot_valid_q;
	logic                 accept;
	logic                 issue;
	logic                 hit;
	logic                 last;
	logic                 finish;
	tst_stk_req_t         stk_req;
	logic [SW-1:0]        pop_slot;
	logic [CW-1:0]        free_cnt;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// scan compare on the registered read
	assign issue  = (state_q == S_SCAN) && (scan_addr_q < CW'(MAX_TASKS));
	assign hit    = vld_s1 && active_q[idx_s1] && (rd_data_s1 == id_q);
	assign last   = vld_s1 && (idx_s1 == SW'(MAX_TASKS - 1));
	assign finish = hit || last;

	// free stack requests
	assign stk_req.pop  = (state_q == S_SCAN) && finish && !hit &&
		(mode_q == MODE_CREATE) && (free_cnt != '0);
	assign stk_req.push = (state_q == S_SCAN) && hit && (mode_q == MODE_REMOVE);

	tst_free_stack #(
		.MAX_TASKS(MAX_TASKS)
	) u_free_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (stk_req),
		.push_slot(idx_s1),
		.pop_slot (pop_slot),
		.free_cnt (free_cnt)
	);

	// id memory: written on create, read at most once per scan cycle
	always_ff @(posedge clk) begin
		if (state_q == S_POP) begin
			id_mem[pop_slot] <= id_q;
		end
		if (issue) begin
			rd_data_s1 <= id_mem[scan_addr_q[SW-1:0]];
			idx_s1     <= scan_addr_q[SW-1:0];
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			id_q   <= task_id;
		end
	end

	// sequencer, active marks and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			scan_addr_q  <= '0;
			vld_s1       <= 1'b0;
			active_q     <= '0;
			done_q       <= 1'b0;
			status_q     <= ST_MISSING;
			slot_q       <= '0;
			slot_valid_q <= 1'b0;
		end else begin
			done_q       <= 1'b0;
			slot_q       <= '0;
			slot_valid_q <= 1'b0;
			vld_s1       <= issue && !finish;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						scan_addr_q <= '0;
						case (mode)
							MODE_LOOKUP: state_q <= S_SCAN;
							MODE_CREATE, MODE_REMOVE: begin
								if (task_id == '0) begin
									done_q   <= 1'b1;
									status_q <= ST_ZERO;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= ST_MISSING;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue) begin
						scan_addr_q <= scan_addr_q + 1'b1;
					end
					if (finish) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						if (mode_q == MODE_CREATE) begin
							if (hit) begin
								status_q <= ST_EXISTS;
							end else if (free_cnt == '0) begin
								status_q <= ST_FULL;
							end else begin
								state_q <= S_POP;
								done_q  <= 1'b0;
							end
						end else if (hit) begin
							status_q     <= ST_OK;
							slot_q       <= 4'(idx_s1);
							slot_valid_q <= 1'b1;
							if (mode_q == MODE_REMOVE) begin
								active_q[idx_s1] <= 1'b0;
							end
						end else begin
							status_q <= ST_MISSING;
						end
					end
				end
				S_POP: begin
					active_q[pop_slot] <= 1'b1;
					state_q            <= S_IDLE;
					done_q             <= 1'b1;
					status_q           <= ST_OK;
					slot_q             <= 4'(pop_slot);
					slot_valid_q       <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign slot_index = slot_q;
	assign slot_valid = slot_valid_q;

	// checks
	a_slot_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (slot_valid == (status == ST_OK)))
		else $error("slot_valid disagrees with status");

	a_pool_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		(($countones(active_q) + int'(free_cnt)) == MAX_TASKS))
		else $error("active slots and free count out of balance");

	a_pop_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> ($past(state_q) == S_SCAN && !done))
		else $error("slot pop outside a create");

	a_request_answered: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done || busy))
		else $error("request neither answered nor in progress");

endmodule
